// ===== hdl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the sine product field evaluator: field
// widths, angle reduction constants, series divisors and pipeline latencies.
// ----------------------------------------------------------------------------
`default_nettype none

package spf_pkg;

  // field widths
  localparam int POS_W   = 32;
  localparam int OMEGA_W = 24;
  localparam int FIELD_W = 18;
  localparam int GRAD_W  = 26;
  localparam int SEC_W   = 34;

  localparam logic [OMEGA_W-1:0] OMEGA_RESET = 24'd65536;

  // angle reduction, Q.32 angles
  localparam logic [32:0] HALF_PI     = 33'd6746518852;
  localparam logic [34:0] FULL_TURN   = 35'd26986075408;
  localparam logic [21:0] TURN_RECIP  = 22'((64'd1 << 56) / 64'(FULL_TURN));
  localparam logic [34:0] TURN_OFFSET = 35'((64'd1 << 55) % 64'(FULL_TURN));

  // taylor series divisors, one per term
  localparam int NTERM     = 7;
  localparam int SIN_TERMS = 6;
  localparam int SIN_DIV [SIN_TERMS] = '{6, 20, 42, 72, 110, 156};
  localparam int COS_DIV [NTERM]     = '{2, 12, 30, 56, 90, 132, 182};

  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  // pipeline latencies in cycles
  localparam int SC_LAT    = 21;
  localparam int PROD_LAT  = 5;
  localparam int TOTAL_LAT = SC_LAT + PROD_LAT;

  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } quad_t;

  // sine and cosine of one axis, Q2.30
  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } trig_t;

endpackage

`default_nettype wire

// ===== hdl/spf_ifs.sv =====
// ----------------------------------------------------------------------------
// spf channel interfaces
// Valid/ready channels of the evaluator: configuration write, input point
// and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface spf_cfg_if import spf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OMEGA_W-1:0] omega;

  modport source (output valid, output omega, input ready);
  modport sink   (input valid, input omega, output ready);
endinterface

interface spf_point_if import spf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface spf_result_if import spf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] field_value;
  logic signed [GRAD_W-1:0]  grad_x;
  logic signed [GRAD_W-1:0]  grad_y;
  logic signed [GRAD_W-1:0]  grad_z;
  logic signed [SEC_W-1:0]   second_pure;
  logic signed [SEC_W-1:0]   second_xy;
  logic signed [SEC_W-1:0]   second_xz;
  logic signed [SEC_W-1:0]   second_yz;

  modport source (output valid, output field_value, output grad_x, output grad_y,
                  output grad_z, output second_pure, output second_xy,
                  output second_xz, output second_yz, input ready);
  modport sink   (input valid, input field_value, input grad_x, input grad_y,
                  input grad_z, input second_pure, input second_xy,
                  input second_xz, input second_yz, output ready);
endinterface

`default_nettype wire

// ===== hdl/spf_sincos.sv =====
// ----------------------------------------------------------------------------
// spf_sincos
// Pipelined sine and cosine of omega times one coordinate: exact angle,
// reduction modulo two pi, quadrant fold and a staged taylor series.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_sincos import spf_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [OMEGA_W-1:0]      omega,
  input  logic signed [POS_W-1:0] pos,
  output trig_t                   trig
);

  localparam logic [34:0] HP1 = {2'b00, HALF_PI};
  localparam logic [34:0] HP2 = HP1 << 1;
  localparam logic [34:0] HP3 = HP1 + HP2;
  localparam logic signed [37:0] TURN_S   = $signed({3'b000, FULL_TURN});
  localparam logic signed [37:0] TURN2_S  = $signed({2'b00, FULL_TURN, 1'b0});
  localparam logic signed [37:0] OFFSET_S = $signed({3'b000, TURN_OFFSET});
  localparam logic signed [33:0] ONE_S    = $signed({3'b000, Q30_ONE});

  // stage 1: exact angle omega * pos
  logic signed [55:0] ang;
  always_ff @(posedge clk) begin
    if (en) begin
      ang <= $signed({32'd0, omega}) * $signed({{24{pos[POS_W-1]}}, pos});
    end
  end

  // stage 2: biased angle and quotient estimate by reciprocal
  logic [55:0] u1;
  logic [53:0] qprod;
  logic [55:0] u2;
  logic [21:0] qe;
  assign u1    = {~ang[55], ang[54:0]};
  assign qprod = {22'd0, u1[55:24]} * {32'd0, TURN_RECIP};
  always_ff @(posedge clk) begin
    if (en) begin
      u2 <= u1;
      qe <= qprod[53:32];
    end
  end

  // stage 3: remainder, short of at most two turns
  logic [56:0] tprod;
  logic [55:0] rdiff;
  logic [36:0] r3;
  assign tprod = {35'd0, qe} * {22'd0, FULL_TURN};
  assign rdiff = u2 - tprod[55:0];
  always_ff @(posedge clk) begin
    if (en) begin
      r3 <= rdiff[36:0];
    end
  end

  // stage 4: remove bias and normalize into one turn
  logic signed [37:0] roff;
  logic signed [37:0] rnorm;
  logic [34:0] rm;
  always_comb begin
    roff = $signed({1'b0, r3}) - OFFSET_S;
    if (roff < 0) begin
      rnorm = roff + TURN_S;
    end else if (roff < TURN_S) begin
      rnorm = roff;
    end else if (roff < TURN2_S) begin
      rnorm = roff - TURN_S;
    end else begin
      rnorm = roff - TURN2_S;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rm <= rnorm[34:0];
    end
  end

  // stage 5: quadrant fold
  logic [34:0] fbase;
  logic [34:0] frac;
  quad_t       qsel;
  logic [30:0] x5;
  quad_t       q5;
  always_comb begin
    if (rm >= HP3) begin
      qsel  = QUAD_IV;
      fbase = HP3;
    end else if (rm >= HP2) begin
      qsel  = QUAD_III;
      fbase = HP2;
    end else if (rm >= HP1) begin
      qsel  = QUAD_II;
      fbase = HP1;
    end else begin
      qsel  = QUAD_I;
      fbase = '0;
    end
    frac = rm - fbase;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x5 <= frac[32:2];
      q5 <= qsel;
    end
  end

  // stage 6: x squared
  logic [61:0] xsq;
  logic [31:0] x2_6;
  logic [30:0] x_6;
  quad_t       q_6;
  assign xsq = {31'd0, x5} * {31'd0, x5};
  always_ff @(posedge clk) begin
    if (en) begin
      x2_6 <= xsq[61:30];
      x_6  <= x5;
      q_6  <= q5;
    end
  end

  // series terms: a multiply stage and a divide stage per term
  logic [31:0]        x2_m [NTERM];
  logic [31:0]        x2_d [NTERM];
  quad_t              q_m  [NTERM];
  quad_t              q_d  [NTERM];
  logic [31:0]        cp_m [NTERM];
  logic [31:0]        ct_d [NTERM];
  logic signed [33:0] cs_m [NTERM];
  logic signed [33:0] cs_d [NTERM];
  logic signed [33:0] sn_m [NTERM];
  logic signed [33:0] sn_d [NTERM];
  logic [31:0]        sp_m [SIN_TERMS];
  logic [31:0]        st_d [SIN_TERMS];

  genvar k;
  for (k = 0; k < NTERM; k++) begin : g_term
    localparam int CD = COS_DIV[k];
    localparam int CL = $clog2(CD);
    localparam logic [32:0] CM =
      33'(((65'd1 << (32 + CL)) + 65'(CD) - 65'd1) / 65'(CD));

    logic [31:0]        x2_in;
    logic [31:0]        ct_in;
    quad_t              q_in;
    logic signed [33:0] cs_in;
    logic signed [33:0] sn_in;
    logic [63:0]        cprod_m;
    logic [64:0]        cprod_d;
    logic [31:0]        ct_new;

    if (k == 0) begin : g_first
      assign x2_in = x2_6;
      assign ct_in = {1'b0, Q30_ONE};
      assign q_in  = q_6;
      assign cs_in = ONE_S;
      assign sn_in = $signed({3'b000, x_6});
    end else begin : g_next
      assign x2_in = x2_d[k-1];
      assign ct_in = ct_d[k-1];
      assign q_in  = q_d[k-1];
      assign cs_in = cs_d[k-1];
      assign sn_in = sn_d[k-1];
    end

    assign cprod_m = {32'd0, ct_in} * {32'd0, x2_in};
    assign cprod_d = {33'd0, cp_m[k]} * {32'd0, CM};
    assign ct_new  = 32'(cprod_d >> (32 + CL));

    // cosine term and the pass-along of shared values
    always_ff @(posedge clk) begin
      if (en) begin
        x2_m[k] <= x2_in;
        q_m[k]  <= q_in;
        cp_m[k] <= cprod_m[61:30];
        cs_m[k] <= cs_in;
        sn_m[k] <= sn_in;
        x2_d[k] <= x2_m[k];
        q_d[k]  <= q_m[k];
        ct_d[k] <= ct_new;
        if ((k % 2) == 0) begin
          cs_d[k] <= cs_m[k] - $signed({2'b00, ct_new});
        end else begin
          cs_d[k] <= cs_m[k] + $signed({2'b00, ct_new});
        end
      end
    end

    if (k < SIN_TERMS) begin : g_sin
      localparam int SD = SIN_DIV[k];
      localparam int SL = $clog2(SD);
      localparam logic [32:0] SM =
        33'(((65'd1 << (32 + SL)) + 65'(SD) - 65'd1) / 65'(SD));

      logic [31:0] st_in;
      logic [63:0] sprod_m;
      logic [64:0] sprod_d;
      logic [31:0] st_new;

      if (k == 0) begin : g_sfirst
        assign st_in = {1'b0, x_6};
      end else begin : g_snext
        assign st_in = st_d[k-1];
      end

      assign sprod_m = {32'd0, st_in} * {32'd0, x2_in};
      assign sprod_d = {33'd0, sp_m[k]} * {32'd0, SM};
      assign st_new  = 32'(sprod_d >> (32 + SL));

      // sine term
      always_ff @(posedge clk) begin
        if (en) begin
          sp_m[k] <= sprod_m[61:30];
          st_d[k] <= st_new;
          if ((k % 2) == 0) begin
            sn_d[k] <= sn_m[k] - $signed({2'b00, st_new});
          end else begin
            sn_d[k] <= sn_m[k] + $signed({2'b00, st_new});
          end
        end
      end
    end else begin : g_sin_pass
      always_ff @(posedge clk) begin
        if (en) begin
          sn_d[k] <= sn_m[k];
        end
      end
    end
  end

  // final stage: clamp to the unit range and unfold the quadrant
  function automatic logic signed [31:0] unit_clamp(logic signed [33:0] v);
    logic signed [31:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ONE_S) begin
      r = $signed({1'b0, Q30_ONE});
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [31:0] sf;
  logic signed [31:0] cf;
  trig_t              trig_next;
  always_comb begin
    sf = unit_clamp(sn_d[NTERM-1]);
    cf = unit_clamp(cs_d[NTERM-1]);
    case (q_d[NTERM-1])
      QUAD_I: begin
        trig_next.s = sf;
        trig_next.c = cf;
      end
      QUAD_II: begin
        trig_next.s = cf;
        trig_next.c = -sf;
      end
      QUAD_III: begin
        trig_next.s = -sf;
        trig_next.c = -cf;
      end
      default: begin
        trig_next.s = -cf;
        trig_next.c = sf;
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (en) begin
      trig <= trig_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sine_product_field_eval_top.sv =====
// ----------------------------------------------------------------------------
// sine_product_field_eval_top
// Evaluates sin(wx)sin(wy)sin(wz) with its gradient, pure second derivative
// and mixed second derivatives at one Q16.16 point per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : write channel for omega (unsigned Q8.16); always ready. Write it
//            only while no point is in flight.
//   point  : input channel, one point per transaction.
//   result : output channel, one result per point, in order.
// Each accepted point passes through the per-axis sine/cosine pipeline
// (angle multiply, reduction, quadrant fold and a two-stage step per series
// term) and then the product, scaling and saturation stages ending in the
// output register.
// Throughput is one point per cycle while result.ready stays high.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and point.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads omega with 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_product_field_eval_top import spf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  spf_cfg_if.sink      cfg,
  spf_point_if.sink    point,
  spf_result_if.source result
);

  // configuration register
  logic [OMEGA_W-1:0] omega;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= OMEGA_RESET;
    end else if (cfg.valid) begin
      omega <= cfg.omega;
    end
  end

  // pipeline advance and valid bits
  logic                 advance;
  logic [TOTAL_LAT-1:0] vld;
  assign advance     = !vld[TOTAL_LAT-1] || result.ready;
  assign point.ready = advance;
  assign result.valid = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[TOTAL_LAT-2:0], point.valid};
    end
  end

  // per-axis sine and cosine
  trig_t tr [3];
  spf_sincos u_sc_x (.clk(clk), .en(advance), .omega(omega), .pos(point.pos_x),
                     .trig(tr[0]));
  spf_sincos u_sc_y (.clk(clk), .en(advance), .omega(omega), .pos(point.pos_y),
                     .trig(tr[1]));
  spf_sincos u_sc_z (.clk(clk), .en(advance), .omega(omega), .pos(point.pos_z),
                     .trig(tr[2]));

  function automatic logic [30:0] mag32(logic signed [31:0] v);
    logic [31:0] n;
    n = v[31] ? 32'(-v) : 32'(v);
    return n[30:0];
  endfunction

  // rounded Q2.30 product of two magnitudes
  function automatic logic [30:0] mul_q30(logic [30:0] a, logic [30:0] b);
    logic [61:0] p;
    p = ({31'd0, a} * {31'd0, b}) + 62'(1 << 29);
    return p[60:30];
  endfunction

  // stage p1: first level products
  logic [30:0] s0s1_m, c0s1_m, s0c1_m, c0c1_m, s2_m, c2_m;
  logic        s0s1_n, c0s1_n, s0c1_n, c0c1_n, s2_n, c2_n;
  always_ff @(posedge clk) begin
    if (advance) begin
      s0s1_m <= mul_q30(mag32(tr[0].s), mag32(tr[1].s));
      c0s1_m <= mul_q30(mag32(tr[0].c), mag32(tr[1].s));
      s0c1_m <= mul_q30(mag32(tr[0].s), mag32(tr[1].c));
      c0c1_m <= mul_q30(mag32(tr[0].c), mag32(tr[1].c));
      s0s1_n <= tr[0].s[31] ^ tr[1].s[31];
      c0s1_n <= tr[0].c[31] ^ tr[1].s[31];
      s0c1_n <= tr[0].s[31] ^ tr[1].c[31];
      c0c1_n <= tr[0].c[31] ^ tr[1].c[31];
      s2_m   <= mag32(tr[2].s);
      c2_m   <= mag32(tr[2].c);
      s2_n   <= tr[2].s[31];
      c2_n   <= tr[2].c[31];
    end
  end

  // stage p2: triple products
  logic [30:0] p_m, g0_m, g1_m, g2_m, m01_m, m02_m, m12_m;
  logic        p_n, g0_n, g1_n, g2_n, m01_n, m02_n, m12_n;
  always_ff @(posedge clk) begin
    if (advance) begin
      p_m   <= mul_q30(s0s1_m, s2_m);
      g0_m  <= mul_q30(c0s1_m, s2_m);
      g1_m  <= mul_q30(s0c1_m, s2_m);
      g2_m  <= mul_q30(s0s1_m, c2_m);
      m01_m <= mul_q30(c0c1_m, s2_m);
      m02_m <= mul_q30(c0s1_m, c2_m);
      m12_m <= mul_q30(s0c1_m, c2_m);
      p_n   <= s0s1_n ^ s2_n;
      g0_n  <= c0s1_n ^ s2_n;
      g1_n  <= s0c1_n ^ s2_n;
      g2_n  <= s0s1_n ^ c2_n;
      m01_n <= c0c1_n ^ s2_n;
      m02_n <= c0s1_n ^ c2_n;
      m12_n <= s0c1_n ^ c2_n;
    end
  end

  // round(w * v / 2^30)
  function automatic logic [24:0] scale_grad(logic [OMEGA_W-1:0] w, logic [30:0] v);
    logic [54:0] p;
    p = ({31'd0, w} * {24'd0, v}) + 55'(1 << 29);
    return p[54:30];
  endfunction

  // round(w * v / 2^16)
  function automatic logic [38:0] scale_inner(logic [OMEGA_W-1:0] w, logic [30:0] v);
    logic [54:0] p;
    p = ({31'd0, w} * {24'd0, v}) + 55'(1 << 15);
    return p[54:16];
  endfunction

  // round(w * v / 2^30) on the inner value
  function automatic logic [32:0] scale_outer(logic [OMEGA_W-1:0] w, logic [38:0] v);
    logic [62:0] p;
    p = ({39'd0, w} * {24'd0, v}) + 63'(1 << 29);
    return p[62:30];
  endfunction

  // stage p3: field rounding, gradient scaling, first omega of second terms
  logic [16:0] f3_m;
  logic [24:0] gx3_m, gy3_m, gz3_m;
  logic [38:0] ip_m, i01_m, i02_m, i12_m;
  logic        f3_n, gx3_n, gy3_n, gz3_n, ip_n, i01_n, i02_n, i12_n;
  logic [30:0] f_round;
  assign f_round = p_m + 31'(1 << 13);
  always_ff @(posedge clk) begin
    if (advance) begin
      f3_m  <= f_round[30:14];
      gx3_m <= scale_grad(omega, g0_m);
      gy3_m <= scale_grad(omega, g1_m);
      gz3_m <= scale_grad(omega, g2_m);
      ip_m  <= scale_inner(omega, p_m);
      i01_m <= scale_inner(omega, m01_m);
      i02_m <= scale_inner(omega, m02_m);
      i12_m <= scale_inner(omega, m12_m);
      f3_n  <= p_n;
      gx3_n <= g0_n;
      gy3_n <= g1_n;
      gz3_n <= g2_n;
      ip_n  <= ~p_n;
      i01_n <= m01_n;
      i02_n <= m02_n;
      i12_n <= m12_n;
    end
  end

  // stage p4: second omega of second terms
  logic [16:0] f4_m;
  logic [24:0] gx4_m, gy4_m, gz4_m;
  logic [32:0] hp_m, h01_m, h02_m, h12_m;
  logic        f4_n, gx4_n, gy4_n, gz4_n, hp_n, h01_n, h02_n, h12_n;
  always_ff @(posedge clk) begin
    if (advance) begin
      f4_m  <= f3_m;
      gx4_m <= gx3_m;
      gy4_m <= gy3_m;
      gz4_m <= gz3_m;
      hp_m  <= scale_outer(omega, ip_m);
      h01_m <= scale_outer(omega, i01_m);
      h02_m <= scale_outer(omega, i02_m);
      h12_m <= scale_outer(omega, i12_m);
      f4_n  <= f3_n;
      gx4_n <= gx3_n;
      gy4_n <= gy3_n;
      gz4_n <= gz3_n;
      hp_n  <= ip_n;
      h01_n <= i01_n;
      h02_n <= i02_n;
      h12_n <= i12_n;
    end
  end

  // saturate the magnitude and apply the sign
  function automatic logic signed [FIELD_W-1:0] pack_field(logic [16:0] m, logic neg);
    logic [FIELD_W-1:0] v;
    v = {1'b0, (m > 17'd65536) ? 17'd65536 : m};
    return neg ? $signed(-v) : $signed(v);
  endfunction

  function automatic logic signed [GRAD_W-1:0] pack_grad(logic [24:0] m, logic neg);
    logic [GRAD_W-1:0] v;
    v = {1'b0, (m > 25'd16777216) ? 25'd16777216 : m};
    return neg ? $signed(-v) : $signed(v);
  endfunction

  function automatic logic signed [SEC_W-1:0] pack_sec(logic [32:0] m, logic neg);
    logic [SEC_W-1:0] v;
    v = {1'b0, (m > 33'd4294967296) ? 33'd4294967296 : m};
    return neg ? $signed(-v) : $signed(v);
  endfunction

  // stage p5: output register
  always_ff @(posedge clk) begin
    if (advance) begin
      result.field_value <= pack_field(f4_m, f4_n);
      result.grad_x      <= pack_grad(gx4_m, gx4_n);
      result.grad_y      <= pack_grad(gy4_m, gy4_n);
      result.grad_z      <= pack_grad(gz4_m, gz4_n);
      result.second_pure <= pack_sec(hp_m, hp_n);
      result.second_xy   <= pack_sec(h01_m, h01_n);
      result.second_xz   <= pack_sec(h02_m, h02_n);
      result.second_yz   <= pack_sec(h12_m, h12_n);
    end
  end

  // accepted point enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> vld[0])
    else $error("accepted point did not enter the pipeline");

  // a stall freezes every valid bit
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vld))
    else $error("valid bits moved during a stall");

  // field value stays within its range
  a_field_rng: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.field_value <= 18'sd65536 &&
                      result.field_value >= -18'sd65536))
    else $error("field value out of range");

  // x and y gradient components stay within their range
  a_grad_rng: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.grad_x <= 26'sd16777216 && result.grad_x >= -26'sd16777216 &&
                      result.grad_y <= 26'sd16777216 && result.grad_y >= -26'sd16777216))
    else $error("gradient out of range");

endmodule

`default_nettype wire

// ===== verif/tb_sine_product_field_eval_top.sv =====
// ----------------------------------------------------------------------------
// tb_sine_product_field_eval_top
// Self-checking bench for the sine product field evaluator. Points go in
// through a queue-fed driver. A bit-exact fixed-point predictor computes the
// expected field, gradient and second derivatives. A monitor compares each
// result transaction with the oldest prediction. Omega is rewritten between
// idle phases, including its extremes.
// ----------------------------------------------------------------------------
module tb_sine_product_field_eval_top;
  import spf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] fv;
    logic signed [GRAD_W-1:0]  gx;
    logic signed [GRAD_W-1:0]  gy;
    logic signed [GRAD_W-1:0]  gz;
    logic signed [SEC_W-1:0]   hp;
    logic signed [SEC_W-1:0]   hxy;
    logic signed [SEC_W-1:0]   hxz;
    logic signed [SEC_W-1:0]   hyz;
  } field_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spf_cfg_if    cfg_ch();
  spf_point_if  pt_ch();
  spf_result_if res_ch();

  sine_product_field_eval_top dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch.sink), .point(pt_ch.sink),
    .result(res_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state and queues
  logic [OMEGA_W-1:0] cur_omega;
  point_t     pending_pts[$];
  field_res_t expected_res[$];
  int  mismatches = 0;
  bit  stim_done = 1'b0;
  bit  calm = 1'b0;
  int  drv_gap = 0;
  int  mon_stall = 0;

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint rnd_scale(longint unsigned k, longint v, int sh);
    longint unsigned m;
    m = (k * mag_of(v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint unsigned m;
    m = (mag_of(a) * mag_of(b) + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v < -lim ? -lim : (v > lim ? lim : v);
  endfunction

  // sine and cosine of omega*pos in Q2.30
  function automatic void axis_trig(logic signed [POS_W-1:0] pos, output longint s,
                                    output longint c);
    longint half, turn, r, sn, cs;
    longint unsigned x, x2, t;
    int q;
    half = 64'd6746518852;
    turn = 4 * half;
    r = (longint'(cur_omega) * longint'(pos)) % turn;
    if (r < 0) r += turn;
    q = int'(r / half);
    if (q > 3) q = 3;
    x = longint'(r - q * half) >> 2;
    x2 = (x * x) >> 30;
    sn = longint'(x);
    t = x;
    for (int k = 1; k <= 6; k++) begin
      t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
      sn = (k & 1) ? sn - longint'(t) : sn + longint'(t);
    end
    cs = 64'd1073741824;
    t = 64'd1073741824;
    for (int k = 1; k <= 7; k++) begin
      t = ((t * x2) >> 30) / ((2 * k - 1) * (2 * k));
      cs = (k & 1) ? cs - longint'(t) : cs + longint'(t);
    end
    sn = sn < 0 ? 0 : (sn > 64'd1073741824 ? 64'd1073741824 : sn);
    cs = cs < 0 ? 0 : (cs > 64'd1073741824 ? 64'd1073741824 : cs);
    case (quad_t'(q))
      QUAD_I:   begin s = sn;  c = cs;  end
      QUAD_II:  begin s = cs;  c = -sn; end
      QUAD_III: begin s = -sn; c = -cs; end
      default:  begin s = -cs; c = sn;  end
    endcase
  endfunction

  function automatic longint second_deriv(longint t);
    return rnd_scale(cur_omega, rnd_scale(cur_omega, t, 16), 30);
  endfunction

  function automatic field_res_t eval_field(point_t p);
    longint sx, cx, sy, cy, sz, cz, pr;
    field_res_t r;
    axis_trig(p.x, sx, cx);
    axis_trig(p.y, sy, cy);
    axis_trig(p.z, sz, cz);
    pr = qmul(qmul(sx, sy), sz);
    r.fv  = FIELD_W'(clip(rnd_scale(1, pr, 14), 64'd65536));
    r.gx  = GRAD_W'(clip(rnd_scale(cur_omega, qmul(qmul(cx, sy), sz), 30), 64'd16777216));
    r.gy  = GRAD_W'(clip(rnd_scale(cur_omega, qmul(qmul(sx, cy), sz), 30), 64'd16777216));
    r.gz  = GRAD_W'(clip(rnd_scale(cur_omega, qmul(qmul(sx, sy), cz), 30), 64'd16777216));
    r.hp  = SEC_W'(clip(-second_deriv(pr), 64'd4294967296));
    r.hxy = SEC_W'(clip(second_deriv(qmul(qmul(cx, cy), sz)), 64'd4294967296));
    r.hxz = SEC_W'(clip(second_deriv(qmul(qmul(cx, sy), cz)), 64'd4294967296));
    r.hyz = SEC_W'(clip(second_deriv(qmul(qmul(sx, cy), cz)), 64'd4294967296));
    return r;
  endfunction

  // point driver with random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      pt_ch.valid <= 1'b0;
      pt_ch.pos_x <= '0;
      pt_ch.pos_y <= '0;
      pt_ch.pos_z <= '0;
      drv_gap <= 0;
    end else if (!pt_ch.valid || pt_ch.ready) begin
      if (pt_ch.valid) expected_res.push_back(eval_field({pt_ch.pos_x, pt_ch.pos_y,
                                                          pt_ch.pos_z}));
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        pt_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        drv_gap <= $urandom_range(0, 4);
        pt_ch.valid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        point_t p;
        p = pending_pts.pop_front();
        pt_ch.valid <= 1'b1;
        pt_ch.pos_x <= p.x;
        pt_ch.pos_y <= p.y;
        pt_ch.pos_z <= p.z;
      end else begin
        pt_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      mon_stall <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        field_res_t got, exp_r;
        got = {res_ch.field_value, res_ch.grad_x, res_ch.grad_y, res_ch.grad_z,
               res_ch.second_pure, res_ch.second_xy, res_ch.second_xz, res_ch.second_yz};
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %p", got);
        end else begin
          exp_r = expected_res.pop_front();
          if (got.fv !== exp_r.fv || got.gx !== exp_r.gx || got.gy !== exp_r.gy ||
              got.gz !== exp_r.gz || got.hp !== exp_r.hp || got.hxy !== exp_r.hxy ||
              got.hxz !== exp_r.hxz || got.hyz !== exp_r.hyz) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
      end
      if (mon_stall > 0) begin
        mon_stall <= mon_stall - 1;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        mon_stall <= $urandom_range(0, 4);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 65536 * 200)) - 65536 * 100);
    endcase
  endfunction

  // wait until idle, then write omega
  task automatic set_omega(logic [OMEGA_W-1:0] w);
    while (pending_pts.size() > 0 || pt_ch.valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (TOTAL_LAT + 4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.omega <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_omega = w;
  endtask

  task automatic add_random(int n);
    point_t p;
    repeat (n) begin
      p.x = rand_coord();
      p.y = rand_coord();
      p.z = rand_coord();
      pending_pts.push_back(p);
    end
  endtask

  // stimulus
  initial begin
    logic [OMEGA_W-1:0] omegas[7];
    point_t p;
    omegas = '{24'd0, 24'hFFFFFF, 24'd1, 24'd102944, 24'd1234567, 24'd65536, 24'd300000};
    cfg_ch.valid = 1'b0;
    cfg_ch.omega = '0;
    cur_omega = OMEGA_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, zero, signs, quadrant edges at reset omega
    pending_pts.push_back('{32'sh7FFFFFFF, 32'sh80000000, 32'sd0});
    pending_pts.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000});
    pending_pts.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
    pending_pts.push_back('{32'sd0, 32'sd0, 32'sd0});
    pending_pts.push_back('{32'sd102944, 32'sd102944, 32'sd102944});
    pending_pts.push_back('{-32'sd102944, 32'sd205887, -32'sd308831});
    pending_pts.push_back('{32'sd411775, -32'sd1, 32'sd1});
    pending_pts.push_back('{32'shFFFFFFFF, 32'sh55555555, 32'shAAAAAAAA});
    add_random(40);
    // per omega phase, including extremes
    foreach (omegas[i]) begin
      set_omega(omegas[i]);
      if (i == 1) begin
        pending_pts.push_back('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF});
        pending_pts.push_back('{32'sd65536, 32'sd65536, -32'sd65536});
      end
      if (i == 6) calm = 1'b1;
      add_random(180);
    end
    while (pending_pts.size() > 0 || pt_ch.valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (TOTAL_LAT + 10) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/spf_pkg.sv
hdl/spf_ifs.sv
hdl/spf_sincos.sv
hdl/sine_product_field_eval_top.sv
verif/tb_sine_product_field_eval_top.sv
